// File: rtl/colored_decimal_digit_display_macros.svh
// ----------------------------------------------------------------------------
// Colored decimal digit display: assertion macros
// Wraps concurrent checks so a build can drop them with NO_ASSERTIONS.
// ----------------------------------------------------------------------------
`ifndef COLORED_DECIMAL_DIGIT_DISPLAY_MACROS_SVH
`define COLORED_DECIMAL_DIGIT_DISPLAY_MACROS_SVH

`ifndef NO_ASSERTIONS

// Property checked on every clock edge outside reset
`define CDD_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error("colored_decimal_digit_display: check failed");

// Implication checked on every clock edge outside reset
`define CDD_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("colored_decimal_digit_display: implication failed");

`else

`define CDD_ASSERT(lbl, prop)
`define CDD_ASSERT_IMPL(lbl, ante, cons)

`endif

`endif

// File: rtl/cddd_pkg.sv
// ----------------------------------------------------------------------------
// cddd_pkg
// Shared types, register indexes and constants of the digit display block.
// ----------------------------------------------------------------------------
package cddd_pkg;

  // Parameter defaults
  localparam int DIGITS_DEFAULT      = 8;
  localparam int COLOR_SPOTS_DEFAULT = 4;

  // Spot registers that exist in the register map
  localparam int SPOT_REGS = 4;

  // Positions that fit the digits and digit_enable fields
  localparam int FIELD_POSITIONS = 8;

  // Register map
  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 56;
  localparam logic [CFG_INDEX_W-1:0] REG_SHOW_ZERO    = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_SHOW_LZ      = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_SPOT_COUNT   = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_SPOT_FIRST   = 3'd3;

  // Reset value of a spot: highest threshold, white
  localparam logic [CFG_DATA_W-1:0] SPOT_RESET = 56'h7F_FFFF_FFFF_FFFF;

  // Divide by ten: floor(x * RECIP10 >> RECIP_SHIFT) is exact for x < 2^32
  localparam logic [31:0] RECIP10     = 32'hCCCC_CCCD;
  localparam int          RECIP_SHIFT = 35;

  // Mode flags seen by every digit stage
  typedef struct packed {
    logic show_zero;
    logic show_leading_zeros;
  } cfg_t;

  // Payload carried down the pipeline
  typedef struct packed {
    logic [30:0] rest;       // magnitude still to be split into digits
    logic        is_zero;    // input was exactly zero
    logic [31:0] digits;
    logic [7:0]  enable;
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
  } stage_t;

endpackage

// File: rtl/cddd_colour_sel.sv
// ----------------------------------------------------------------------------
// cddd_colour_sel
// Entry stage: compares the value with the spot thresholds, picks the colour
// and prepares the magnitude for digit extraction.
// ----------------------------------------------------------------------------
module cddd_colour_sel #(
  parameter int NSPOT = cddd_pkg::SPOT_REGS
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic [2:0]                       spot_count,
  input  logic [cddd_pkg::CFG_DATA_W-1:0]  spot [NSPOT],
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic [31:0]                      value,
  output logic                             out_valid,
  input  logic                             out_ready,
  output cddd_pkg::stage_t                 out_data
);

  logic [2:0]       n_used;
  logic [23:0]      rgb;
  cddd_pkg::stage_t data_next;

  // Spots in use: clamp to 1..NSPOT
  always_comb begin
    if (spot_count == 3'd0) begin
      n_used = 3'd1;
    end else if (spot_count > 3'(NSPOT)) begin
      n_used = 3'(NSPOT);
    end else begin
      n_used = spot_count;
    end
  end

  // First spot whose threshold is at least the value, else the last in use
  always_comb begin
    logic found;
    logic [23:0] last_rgb;
    found    = 1'b0;
    last_rgb = spot[0][23:0];
    rgb      = 24'd0;
    for (int i = 0; i < NSPOT; i++) begin
      if (i == int'(n_used) - 1) begin
        last_rgb = spot[i][23:0];
      end
      if (!found && (i < int'(n_used)) &&
          ($signed(value) <= $signed(spot[i][55:24]))) begin
        rgb   = spot[i][23:0];
        found = 1'b1;
      end
    end
    if (!found) begin
      rgb = last_rgb;
    end
  end

  // Payload for the digit stages; a negative value has no digits
  always_comb begin
    data_next         = '0;
    data_next.rest    = value[31] ? 31'd0 : value[30:0];
    data_next.is_zero = (value == 32'd0);
    data_next.red     = rgb[23:16];
    data_next.green   = rgb[15:8];
    data_next.blue    = rgb[7:0];
  end

  assign in_ready = !out_valid || out_ready;

  // Stage register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      out_data <= data_next;
    end
  end

endmodule

// File: rtl/cddd_digit_stage.sv
// ----------------------------------------------------------------------------
// cddd_digit_stage
// One pipeline stage: splits off the decimal digit of position POS by a
// reciprocal multiply and decides whether that position is shown.
// ----------------------------------------------------------------------------
module cddd_digit_stage #(
  parameter int POS = 0
) (
  input  logic              clk,
  input  logic              rst,
  input  cddd_pkg::cfg_t    cfg,
  input  logic              in_valid,
  output logic              in_ready,
  input  cddd_pkg::stage_t  in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output cddd_pkg::stage_t  out_data
);

  localparam bit IN_FIELD = (POS < cddd_pkg::FIELD_POSITIONS);
  localparam int FPOS     = IN_FIELD ? POS : 0;
  localparam bit FIRST    = (POS == 0);

  logic [62:0]      prod;
  logic [27:0]      quot;
  logic [30:0]      quot10;
  logic [30:0]      remd;
  logic [3:0]       dig;
  logic             show;
  cddd_pkg::stage_t data_next;

  // rest / 10 and rest % 10
  assign prod   = 63'(in_data.rest) * 63'(cddd_pkg::RECIP10);
  assign quot   = prod[62:cddd_pkg::RECIP_SHIFT];
  assign quot10 = (31'(quot) << 3) + (31'(quot) << 1);
  assign remd   = in_data.rest - quot10;
  assign dig    = remd[3:0];

  // Position visibility
  always_comb begin
    if (in_data.is_zero) begin
      show = cfg.show_zero && (FIRST || cfg.show_leading_zeros);
    end else if (in_data.rest != 31'd0) begin
      show = 1'b1;
    end else begin
      show = cfg.show_leading_zeros;
    end
  end

  always_comb begin
    data_next      = in_data;
    data_next.rest = 31'(quot);
    if (IN_FIELD) begin
      data_next.digits[4*FPOS +: 4] = show ? dig : 4'd0;
      data_next.enable[FPOS]        = show;
    end
  end

  assign in_ready = !out_valid || out_ready;

  // Stage register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      out_data <= data_next;
    end
  end

endmodule

// File: rtl/colored_decimal_digit_display.sv
// A request is registered in the colour stage, then in each digit stage.
// Throughput: one request per cycle while out_ready is high; the colour stage
// and one stage per digit position, each with its own divide-by-ten multiplier,
// are fully pipelined. Backpressure holds full stages; empty ones still fill.
// Reset clears all stage valid bits and returns the mode flags, spot count
// and spots to their defaults; no pass is needed before the first request.
// ----------------------------------------------------------------------------
// colored_decimal_digit_display
// Signed number to decimal digits with leading zero blanking and a colour
// picked from ascending threshold spots.
// ----------------------------------------------------------------------------
`include "colored_decimal_digit_display_macros.svh"

module colored_decimal_digit_display #(
  parameter int DIGITS      = cddd_pkg::DIGITS_DEFAULT,
  parameter int COLOR_SPOTS = cddd_pkg::COLOR_SPOTS_DEFAULT
) (
  input  logic                               clk,
  input  logic                               rst,
  // configuration
  input  logic                               cfg_we,
  input  logic [cddd_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  logic [cddd_pkg::CFG_DATA_W-1:0]    cfg_data,
  // request channel
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic signed [31:0]                 value,
  // result channel
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic [31:0]                        digits,
  output logic [7:0]                         digit_enable,
  output logic [7:0]                         red,
  output logic [7:0]                         green,
  output logic [7:0]                         blue
);

  localparam int NSPOT = (COLOR_SPOTS < cddd_pkg::SPOT_REGS) ?
                         COLOR_SPOTS : cddd_pkg::SPOT_REGS;

  logic                              show_zero;
  logic                              show_leading_zeros;
  logic [2:0]                        spot_count;
  logic [cddd_pkg::CFG_DATA_W-1:0]   spot [NSPOT];
  cddd_pkg::cfg_t                    cfg;

  logic             vld [DIGITS+1];
  logic             rdy [DIGITS+1];
  cddd_pkg::stage_t dat [DIGITS+1];

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      show_zero          <= 1'b1;
      show_leading_zeros <= 1'b0;
      spot_count         <= 3'd1;
    end else if (cfg_we) begin
      unique case (cfg_index)
        cddd_pkg::REG_SHOW_ZERO:  show_zero          <= cfg_data[0];
        cddd_pkg::REG_SHOW_LZ:    show_leading_zeros <= cfg_data[0];
        cddd_pkg::REG_SPOT_COUNT: spot_count         <= cfg_data[2:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NSPOT; i++) begin
        spot[i] <= cddd_pkg::SPOT_RESET;
      end
    end else if (cfg_we) begin
      for (int i = 0; i < NSPOT; i++) begin
        if (cfg_index == cddd_pkg::REG_SPOT_FIRST + cddd_pkg::CFG_INDEX_W'(i)) begin
          spot[i] <= cfg_data;
        end
      end
    end
  end

  assign cfg.show_zero          = show_zero;
  assign cfg.show_leading_zeros = show_leading_zeros;

  // Entry stage: colour pick
  cddd_colour_sel #(
    .NSPOT (NSPOT)
  ) u_colour (
    .clk        (clk),
    .rst        (rst),
    .spot_count (spot_count),
    .spot       (spot),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .value      (value),
    .out_valid  (vld[0]),
    .out_ready  (rdy[0]),
    .out_data   (dat[0])
  );

  // One stage per digit position
  for (genvar p = 0; p < DIGITS; p++) begin : g_digit
    cddd_digit_stage #(
      .POS (p)
    ) u_stage (
      .clk       (clk),
      .rst       (rst),
      .cfg       (cfg),
      .in_valid  (vld[p]),
      .in_ready  (rdy[p]),
      .in_data   (dat[p]),
      .out_valid (vld[p+1]),
      .out_ready (rdy[p+1]),
      .out_data  (dat[p+1])
    );
  end

  // Result channel
  assign rdy[DIGITS]  = out_ready;
  assign out_valid    = vld[DIGITS];
  assign digits       = dat[DIGITS].digits;
  assign digit_enable = dat[DIGITS].enable;
  assign red          = dat[DIGITS].red;
  assign green        = dat[DIGITS].green;
  assign blue         = dat[DIGITS].blue;

  // Checks
  `CDD_ASSERT_IMPL(a_drain_frees_entry, out_ready, in_ready)

  for (genvar i = 0; i < cddd_pkg::FIELD_POSITIONS; i++) begin : g_chk
    `CDD_ASSERT_IMPL(a_digit_decimal, out_valid, digits[4*i +: 4] <= 4'd9)
    `CDD_ASSERT_IMPL(a_hidden_is_zero, out_valid && !digit_enable[i], digits[4*i +: 4] == 4'd0)
  end

endmodule

// File: dv/tb_colored_decimal_digit_display.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_colored_decimal_digit_display
// Self-checking bench for the digit display block. A short list of directed
// requests covers zero, negative and extreme numbers, both mode flags and the
// colour spot rules. Random requests follow over several register settings.
// Each result is checked field by field against typed values or an in-bench
// predictor, with random idle bursts on both channels and one long output stall.
// ----------------------------------------------------------------------------
module tb_colored_decimal_digit_display;

  localparam int RANDOM_ITEMS = 1150;
  localparam int PHASES       = 10;
  localparam int CALM_ITEMS   = 150;   // tail of the run without idling
  localparam int HOLD_CYCLES  = 200;   // long output stall
  localparam int HOLD_AT_ITEM = 300;
  localparam int LIMIT_CYCLES = 200000;

  typedef struct packed {
    logic [31:0] digits;
    logic [7:0]  enable;
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
  } readout_t;

  // One row of the directed list: a register write or a request
  typedef struct {
    bit                                 is_write;
    logic [cddd_pkg::CFG_INDEX_W-1:0]   index;
    logic [cddd_pkg::CFG_DATA_W-1:0]    data;
    logic signed [31:0]                 number;
    bit                                 typed;
    readout_t                           want;
  } row_t;

  logic                               clk = 1'b0;
  logic                               rst = 1'b1;
  logic                               cfg_we = 1'b0;
  logic [cddd_pkg::CFG_INDEX_W-1:0]   cfg_index = '0;
  logic [cddd_pkg::CFG_DATA_W-1:0]    cfg_data = '0;
  logic                               in_valid = 1'b0;
  logic                               in_ready;
  logic signed [31:0]                 value = '0;
  logic                               out_valid;
  logic                               out_ready = 1'b0;
  logic [31:0]                        digits;
  logic [7:0]                         digit_enable;
  logic [7:0]                         red;
  logic [7:0]                         green;
  logic [7:0]                         blue;

  // Register copy used by the predictor
  logic                               m_show_zero = 1'b1;
  logic                               m_show_lz = 1'b0;
  logic [2:0]                         m_spot_count = 3'd1;
  logic [cddd_pkg::CFG_DATA_W-1:0]    m_spots [cddd_pkg::SPOT_REGS];

  readout_t                 pending_readouts [$];
  row_t                     directed_rows [$];
  readout_t                 got;
  int                       mismatch_count = 0;
  int                       requests_sent = 0;
  int                       cycle_count = 0;
  int                       idle_pct = 0;
  int                       stall_left = 0;
  bit                       calm = 1'b0;
  bit                       hold_req = 1'b0;

  colored_decimal_digit_display i_dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .value        (value),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .digits       (digits),
    .digit_enable (digit_enable),
    .red          (red),
    .green        (green),
    .blue         (blue)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Predicted digits, enable mask and colour for one number
  function automatic readout_t compute_readout(input logic signed [31:0] v);
    readout_t           r;
    logic [31:0]        rest;
    logic               show;
    logic [3:0]         d;
    logic signed [31:0] limit_val;
    int                 n;
    int                 sel;
    bit                 found;
    r = '0;
    rest = v[31] ? 32'd0 : v;
    for (int pos = 0; pos < cddd_pkg::FIELD_POSITIONS; pos++) begin
      d = 4'd0;
      if (v == 0) begin
        show = m_show_zero && (pos == 0 || m_show_lz);
      end else if (rest != 0) begin
        d = 4'(rest % 10);
        rest = rest / 10;
        show = 1'b1;
      end else begin
        show = m_show_lz;
      end
      if (show) begin
        r.digits[4*pos +: 4] = d;
        r.enable[pos] = 1'b1;
      end
    end
    // spot count clamps to 1..4
    n = (m_spot_count == 0) ? 1 : int'(m_spot_count);
    if (n > cddd_pkg::SPOT_REGS) n = cddd_pkg::SPOT_REGS;
    sel = n - 1;
    found = 1'b0;
    for (int i = 0; i < n; i++) begin
      limit_val = $signed(m_spots[i][55:24]);
      if (!found && v <= limit_val) begin
        sel = i;
        found = 1'b1;
      end
    end
    r.red   = m_spots[2'(sel)][23:16];
    r.green = m_spots[2'(sel)][15:8];
    r.blue  = m_spots[2'(sel)][7:0];
    return r;
  endfunction

  function automatic void row_write(input logic [cddd_pkg::CFG_INDEX_W-1:0] idx,
                                    input logic [cddd_pkg::CFG_DATA_W-1:0] data);
    row_t r;
    r = '{default: '0};
    r.is_write = 1'b1;
    r.index = idx;
    r.data = data;
    directed_rows = {directed_rows, r};
  endfunction

  function automatic void row_value(input logic signed [31:0] v);
    row_t r;
    r = '{default: '0};
    r.number = v;
    directed_rows = {directed_rows, r};
  endfunction

  // Expected result typed in; colour is the reset spot
  function automatic void row_fixed(input logic signed [31:0] v, input logic [31:0] d,
                                    input logic [7:0] en);
    row_t r;
    r = '{default: '0};
    r.number = v;
    r.typed = 1'b1;
    r.want = {d, en, cddd_pkg::SPOT_RESET[23:0]};
    directed_rows = {directed_rows, r};
  endfunction

  // Random: extremes, short numbers, each length, near thresholds, negatives
  function automatic logic signed [31:0] pick_number();
    logic signed [31:0] v;
    int                 k;
    int unsigned        lim;
    case ($urandom_range(0, 9))
      0: begin
        case ($urandom_range(0, 6))
          0: v = 0;
          1: v = 1;
          2: v = -1;
          3: v = 32'sh7FFF_FFFF;
          4: v = 32'sh8000_0000;
          5: v = 99999999;
          default: v = 100000000;
        endcase
      end
      1, 2: v = $urandom_range(0, 99);
      3, 4, 5: begin
        k = $urandom_range(1, 10);
        if (k == 10) begin
          v = $urandom & 32'h7FFF_FFFF;
        end else begin
          lim = 1;
          for (int i = 0; i < k; i++) lim = lim * 10;
          v = $urandom_range(0, lim - 1);
        end
      end
      6: v = $signed(m_spots[2'($urandom_range(0, cddd_pkg::SPOT_REGS-1))][55:24])
             + $urandom_range(0, 2) - 1;
      7: v = -$signed({1'b0, 31'($urandom_range(1, 1000))});
      default: v = $urandom;
    endcase
    return v;
  endfunction

  task automatic write_register(input logic [cddd_pkg::CFG_INDEX_W-1:0] idx,
                                input logic [cddd_pkg::CFG_DATA_W-1:0] data);
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_data = data;
    case (idx)
      cddd_pkg::REG_SHOW_ZERO:  m_show_zero = data[0];
      cddd_pkg::REG_SHOW_LZ:    m_show_lz = data[0];
      cddd_pkg::REG_SPOT_COUNT: m_spot_count = data[2:0];
      default: begin
        if (idx >= cddd_pkg::REG_SPOT_FIRST &&
            idx < cddd_pkg::REG_SPOT_FIRST + cddd_pkg::SPOT_REGS)
          m_spots[2'(idx - cddd_pkg::REG_SPOT_FIRST)] = data;
      end
    endcase
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  // Block is idle once every result is back; a few spare cycles on top
  task automatic settle();
    while (pending_readouts.size() != 0) @(negedge clk);
    repeat (3) @(negedge clk);
  endtask

  // Offer one request and hold it until accepted
  task automatic offer_value(input logic signed [31:0] v, input bit typed,
                             input readout_t fixed);
    if (!calm && $urandom_range(0, 99) < idle_pct) begin
      in_valid = 1'b0;
      repeat ($urandom_range(1, 8)) @(negedge clk);
    end
    in_valid = 1'b1;
    value = v;
    do @(posedge clk); while (!in_ready);
    pending_readouts = {pending_readouts, (typed ? fixed : compute_readout(v))};
    requests_sent++;
    @(negedge clk);
    in_valid = 1'b0;
  endtask

  task automatic compare_field(input string name, input logic [31:0] want,
                               input logic [31:0] seen);
    if (want !== seen) begin
      $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, seen);
      mismatch_count++;
    end
  endtask

  // Result checker
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (pending_readouts.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual digits %h", $time,
                 digits);
        mismatch_count++;
      end else begin
        got = pending_readouts.pop_front();
        compare_field("digits", got.digits, digits);
        compare_field("digit_enable", 32'(got.enable), 32'(digit_enable));
        compare_field("red", 32'(got.red), 32'(red));
        compare_field("green", 32'(got.green), 32'(green));
        compare_field("blue", 32'(got.blue), 32'(blue));
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= LIMIT_CYCLES) begin
      $display("FAIL colored_decimal_digit_display");
      $finish;
    end
  end

  // Result side: random stalls plus one long hold-off on request
  initial begin
    while (rst) @(negedge clk);
    forever begin
      @(negedge clk);
      if (hold_req) begin
        out_ready = 1'b0;
        repeat (HOLD_CYCLES - 1) @(negedge clk);
        hold_req = 1'b0;
      end else if (stall_left > 0 && !calm) begin
        out_ready = 1'b0;
        stall_left--;
      end else if (!calm && $urandom_range(0, 99) < idle_pct) begin
        out_ready = 1'b0;
        stall_left = $urandom_range(0, 7);
      end else begin
        out_ready = 1'b1;
      end
    end
  end

  // Request side and register phases
  initial begin
    logic signed [31:0] thr [cddd_pkg::SPOT_REGS];
    logic signed [31:0] swap;
    logic [cddd_pkg::CFG_DATA_W-1:0] fill;
    readout_t none;
    none = '0;
    for (int i = 0; i < cddd_pkg::SPOT_REGS; i++) m_spots[i] = cddd_pkg::SPOT_RESET;

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed list: reset settings first, then mode flags, then spots
    row_fixed(0, 32'h0, 8'h01);
    row_fixed(1, 32'h1, 8'h01);
    row_fixed(32'sh7FFF_FFFF, 32'h4748_3647, 8'hFF);
    row_fixed(-1, 32'h0, 8'h00);
    row_fixed(32'sh8000_0000, 32'h0, 8'h00);
    row_fixed(99999999, 32'h9999_9999, 8'hFF);
    row_fixed(100000000, 32'h0, 8'hFF);
    row_fixed(12345, 32'h0001_2345, 8'h1F);
    row_write(cddd_pkg::REG_SHOW_ZERO, '0);
    row_fixed(0, 32'h0, 8'h00);
    row_fixed(7, 32'h7, 8'h01);
    row_write(cddd_pkg::REG_SHOW_LZ, 56'd1);
    row_fixed(0, 32'h0, 8'h00);
    row_fixed(-5, 32'h0, 8'hFF);
    row_write(cddd_pkg::REG_SHOW_ZERO, 56'd1);
    row_fixed(0, 32'h0, 8'hFF);
    row_fixed(42, 32'h42, 8'hFF);
    row_write(cddd_pkg::REG_SHOW_LZ, '0);
    // thresholds -100, 0, 1000 and an out-of-order -50
    row_write(cddd_pkg::REG_SPOT_FIRST,        56'hFFFF_FF9C_1122_33);
    row_write(cddd_pkg::REG_SPOT_FIRST + 3'd1, 56'h0000_0000_4455_66);
    row_write(cddd_pkg::REG_SPOT_FIRST + 3'd2, 56'h0000_03E8_7788_99);
    row_write(cddd_pkg::REG_SPOT_FIRST + 3'd3, 56'hFFFF_FFCE_AABB_CC);
    row_write(cddd_pkg::REG_SPOT_COUNT, 56'd4);
    row_value(-200);
    row_value(-100);
    row_value(-99);
    row_value(0);
    row_value(1000);
    row_value(1001);
    row_write(cddd_pkg::REG_SPOT_COUNT, '0);     // zero count acts as one
    row_value(5000);
    row_write(cddd_pkg::REG_SPOT_COUNT, 56'd7);  // count above four acts as four
    row_value(-60);
    row_write(cddd_pkg::REG_SPOT_COUNT, 56'd3);
    row_value(2000);
    row_write(cddd_pkg::REG_SPOT_FIRST + 3'd3, {cddd_pkg::CFG_DATA_W{1'b1}});
    row_write(cddd_pkg::REG_SPOT_FIRST, '0);
    row_value(0);
    row_write(cddd_pkg::REG_SPOT_COUNT, 56'd4);
    row_value(-2);

    idle_pct = 20;
    foreach (directed_rows[r]) begin
      if (directed_rows[r].is_write) begin
        settle();
        write_register(directed_rows[r].index, directed_rows[r].data);
      end else begin
        offer_value(directed_rows[r].number, directed_rows[r].typed,
                    directed_rows[r].want);
      end
    end

    // Random phases, each under a fresh register setting
    for (int p = 0; p < PHASES; p++) begin
      settle();
      if (p < 2) begin
        fill = (p == 0) ? '0 : {cddd_pkg::CFG_DATA_W{1'b1}};
        for (int i = 0; i < cddd_pkg::SPOT_REGS; i++)
          write_register(cddd_pkg::REG_SPOT_FIRST + 3'(i), fill);
        write_register(cddd_pkg::REG_SPOT_COUNT, fill);
        write_register(cddd_pkg::REG_SHOW_ZERO, fill);
        write_register(cddd_pkg::REG_SHOW_LZ, fill);
      end else begin
        for (int i = 0; i < cddd_pkg::SPOT_REGS; i++)
          thr[i] = $urandom_range(0, 1) ? ($urandom_range(0, 4000) - 2000) : $urandom;
        // ascending thresholds in most phases
        if (p % 4 != 3) begin
          for (int i = 0; i < cddd_pkg::SPOT_REGS - 1; i++)
            for (int j = 0; j < cddd_pkg::SPOT_REGS - 1 - i; j++)
              if (thr[j] > thr[j+1]) begin
                swap = thr[j];
                thr[j] = thr[j+1];
                thr[j+1] = swap;
              end
        end
        for (int i = 0; i < cddd_pkg::SPOT_REGS; i++)
          write_register(cddd_pkg::REG_SPOT_FIRST + 3'(i), {thr[i], 24'($urandom)});
        write_register(cddd_pkg::REG_SPOT_COUNT, 56'($urandom_range(0, 7)));
        write_register(cddd_pkg::REG_SHOW_ZERO, 56'($urandom_range(0, 1)));
        write_register(cddd_pkg::REG_SHOW_LZ, 56'($urandom_range(0, 1)));
      end

      for (int k = 0; k < RANDOM_ITEMS / PHASES; k++) begin
        int n;
        n = p * (RANDOM_ITEMS / PHASES) + k;
        if (n % 40 == 0) begin
          case ($urandom_range(0, 2))
            0: idle_pct = 0;
            1: idle_pct = 15;
            default: idle_pct = 40;
          endcase
        end
        if (n == HOLD_AT_ITEM) hold_req = 1'b1;
        if (n >= RANDOM_ITEMS - CALM_ITEMS) calm = 1'b1;
        offer_value(pick_number(), 1'b0, none);
      end
    end

    // Drain, then allow a full pipeline of spare cycles
    while (pending_readouts.size() != 0) @(negedge clk);
    repeat (20) @(negedge clk);
    if (mismatch_count == 0) begin
      $display("PASS colored_decimal_digit_display");
    end else begin
      $display("FAIL colored_decimal_digit_display");
    end
    $finish;
  end

endmodule

// File: files.f
+incdir+rtl
rtl/cddd_pkg.sv
rtl/cddd_colour_sel.sv
rtl/cddd_digit_stage.sv
rtl/colored_decimal_digit_display.sv
dv/tb_colored_decimal_digit_display.sv
